@@ sv/lsfc_pkg.sv @@
package lsfc_pkg;

  // Field widths of the tick, result and configuration channels.
  localparam int EPOCH_W  = 40;
  localparam int MINUTE_W = 16;
  localparam int MOD_W    = 12;
  localparam int MS_W     = 32;
  localparam int PCT_W    = 7;
  localparam int DUTY_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_VAL_W = 40;

  // Divider widths: the remainder holds anything below period * 60.
  localparam int REM_W = 22;
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(EPOCH_W - 1);

  // Minute of the phase: x / 60 equals (x * RECIP_60) >> RECIP_SHIFT for
  // every x below 2^REM_W.
  localparam int                  RECIP_W     = 23;
  localparam int                  RECIP_SHIFT = 28;
  localparam logic [RECIP_W-1:0]  RECIP_60    = 23'd4473925;

  // Schedule and level constants.
  localparam logic [MINUTE_W-1:0] PERIOD_DAY  = 16'd1440;
  localparam logic [PCT_W-1:0]    PCT_FULL    = 7'd100;
  localparam int                  PWM_MAX     = 1023;
  localparam int                  LIMIT_W     = MS_W + PCT_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ON_MINUTE      = 3'd0,
    CFG_OFF_MINUTE     = 3'd1,
    CFG_PERIOD_MINUTES = 3'd2,
    CFG_CYCLE_ANCHOR   = 3'd3,
    CFG_MAX_LEVEL      = 3'd4,
    CFG_FADE_ENABLE    = 3'd5,
    CFG_FADE_UP_MS     = 3'd6,
    CFG_FADE_DOWN_MS   = 3'd7
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MOD,
    ST_FIX,
    ST_DIV,
    ST_CALC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [EPOCH_W-1:0]      epoch_seconds;
    logic signed [MOD_W-1:0] minute_of_day;
    logic [MS_W-1:0]         now_ms;
  } tick_t;

  typedef struct packed {
    logic [PCT_W-1:0]  level_pct;
    logic [DUTY_W-1:0] pwm_duty;
    logic [PCT_W-1:0]  target_pct;
    logic              schedule_on;
    logic              level_written;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } cfg_t;

  // Duty for each level: level * PWM_MAX / 100, truncated, low bits kept.
  typedef logic [DUTY_W-1:0] duty_tab_t [0:(1 << PCT_W) - 1];

  function automatic duty_tab_t duty_table_f();
    duty_tab_t t;
    for (int i = 0; i < (1 << PCT_W); i++) begin
      t[i] = DUTY_W'((i * PWM_MAX) / 100);
    end
    return t;
  endfunction

  localparam duty_tab_t DUTY_TABLE = duty_table_f();

endpackage

@@ sv/lsfc_if.sv @@
// Tick channel: one update tick per transfer.
interface lsfc_tick_if;
  logic              valid;
  logic              ready;
  lsfc_pkg::tick_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel: one result per tick.
interface lsfc_result_if;
  logic              valid;
  logic              ready;
  lsfc_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface lsfc_cfg_if;
  logic              valid;
  logic              ready;
  lsfc_pkg::cfg_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/light_schedule_fade_controller.sv @@
// Light schedule fade controller. Each tick transfer carries epoch seconds, the
// local minute of day and a free-running millisecond counter; the block decides
// from the on/off window whether the light is on, sets the target level and moves
// the level toward it, then returns one result. In anchored mode the cycle phase
// comes from a restoring divider that retires one bit per cycle to find the
// remainder modulo period * 60, after which a multiply by the reciprocal of 60
// gives the minute. An anchored tick passes through the prep, remainder, fix,
// divide and calc states to done, where its result is registered; a wall-clock
// or forced-off tick goes from prep straight to calc and done. The tick
// channel is ready only while the sequencer is idle; a result waiting on the
// output holds the sequencer in its last state.
// Configuration writes are always accepted and should be made between ticks.
module light_schedule_fade_controller (
  input  logic                clk,
  input  logic                rst,
  lsfc_tick_if.sink           tick,
  lsfc_result_if.source       result,
  lsfc_cfg_if.sink            cfg
);

  // Configuration registers.
  logic [lsfc_pkg::MINUTE_W-1:0] on_minute;
  logic [lsfc_pkg::MINUTE_W-1:0] off_minute;
  logic [lsfc_pkg::MINUTE_W-1:0] period_minutes;
  logic [lsfc_pkg::EPOCH_W-1:0]  cycle_anchor;
  logic [lsfc_pkg::PCT_W-1:0]    max_level;
  logic                          fade_enable;
  logic [lsfc_pkg::MS_W-1:0]     fade_up_ms;
  logic [lsfc_pkg::MS_W-1:0]     fade_down_ms;

  // Block state.
  logic [lsfc_pkg::PCT_W-1:0]    level;
  logic [lsfc_pkg::MS_W-1:0]     last_step_time;

  // Sequencer and datapath registers.
  lsfc_pkg::state_t              state, state_next;
  lsfc_pkg::tick_t               tick_r;
  logic [lsfc_pkg::CNT_W-1:0]    cnt;
  logic [lsfc_pkg::EPOCH_W-1:0]  dividend;
  logic [lsfc_pkg::REM_W-1:0]    rem;
  logic [lsfc_pkg::REM_W-1:0]    period_sec;
  logic                          neg;
  logic                          anchored_path;
  logic                          forced_off;
  logic [lsfc_pkg::MINUTE_W-1:0] minute;
  logic                          sched_valid;
  logic                          on_r;
  logic [lsfc_pkg::PCT_W-1:0]    target_r;
  logic [lsfc_pkg::MS_W-1:0]     fade_sel;
  logic [lsfc_pkg::LIMIT_W-1:0]  limit;
  logic                          elapsed_nz;
  logic                          out_valid;
  lsfc_pkg::result_t             out_data;

  // Control outputs of the sequencer.
  logic tick_take;
  logic out_load;
  logic out_free;

  // ---------------------------------------------------------------------------
  // Configuration port.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_minute      <= '0;
      off_minute     <= '0;
      period_minutes <= lsfc_pkg::PERIOD_DAY;
      cycle_anchor   <= '0;
      max_level      <= lsfc_pkg::PCT_FULL;
      fade_enable    <= 1'b0;
      fade_up_ms     <= '0;
      fade_down_ms   <= '0;
    end else if (cfg.valid) begin
      unique case (lsfc_pkg::cfg_idx_t'(cfg.data.index))
        lsfc_pkg::CFG_ON_MINUTE:      on_minute      <= cfg.data.value[15:0];
        lsfc_pkg::CFG_OFF_MINUTE:     off_minute     <= cfg.data.value[15:0];
        lsfc_pkg::CFG_PERIOD_MINUTES: period_minutes <= cfg.data.value[15:0];
        lsfc_pkg::CFG_CYCLE_ANCHOR:   cycle_anchor   <= cfg.data.value[39:0];
        lsfc_pkg::CFG_MAX_LEVEL:      max_level      <= cfg.data.value[6:0];
        lsfc_pkg::CFG_FADE_ENABLE:    fade_enable    <= cfg.data.value[0];
        lsfc_pkg::CFG_FADE_UP_MS:     fade_up_ms     <= cfg.data.value[31:0];
        lsfc_pkg::CFG_FADE_DOWN_MS:   fade_down_ms   <= cfg.data.value[31:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divide step: shift one dividend bit into the remainder and
  // subtract the divisor when it fits. The quotient bit enters the dividend LSB.
  logic [lsfc_pkg::REM_W:0]   rem_sh;
  logic [lsfc_pkg::REM_W+1:0] sub;
  logic                       fits;
  logic [lsfc_pkg::REM_W-1:0] rem_step;

  always_comb begin
    rem_sh   = {rem, dividend[lsfc_pkg::EPOCH_W-1]};
    sub      = {1'b0, rem_sh} - {2'b00, period_sec};
    fits     = ~sub[lsfc_pkg::REM_W+1];
    rem_step = fits ? sub[lsfc_pkg::REM_W-1:0] : rem_sh[lsfc_pkg::REM_W-1:0];
  end

  // Signed distance from the anchor, taken as sign and magnitude.
  logic [lsfc_pkg::EPOCH_W:0]   diff;
  logic [lsfc_pkg::EPOCH_W:0]   diff_neg;
  logic [lsfc_pkg::REM_W-1:0]   rem_fixed;
  logic [lsfc_pkg::REM_W+lsfc_pkg::RECIP_W-1:0] quot_prod;

  always_comb begin
    diff      = {1'b0, tick_r.epoch_seconds} - {1'b0, cycle_anchor};
    diff_neg  = -diff;
    rem_fixed = (neg && (rem != '0)) ? (period_sec - rem) : rem;
    quot_prod = {{lsfc_pkg::RECIP_W{1'b0}}, rem} *
                {{lsfc_pkg::REM_W{1'b0}}, lsfc_pkg::RECIP_60};
  end

  // Forced off: no anchor, no valid time or a zero period.
  assign forced_off = (cycle_anchor == '0) || (tick_r.epoch_seconds == '0) ||
                      (period_minutes == '0);

  // ---------------------------------------------------------------------------
  // Schedule decision and fade pacing.
  logic                         win;
  logic                         on_now;
  logic [lsfc_pkg::PCT_W-1:0]   target_now;
  logic [lsfc_pkg::MS_W-1:0]    elapsed;
  logic [lsfc_pkg::LIMIT_W-1:0] elapsed_ext;

  always_comb begin
    if (on_minute == off_minute) begin
      win = 1'b1;
    end else if (on_minute < off_minute) begin
      win = (minute >= on_minute) && (minute < off_minute);
    end else begin
      win = (minute >= on_minute) || (minute < off_minute);
    end
    on_now      = sched_valid && win;
    target_now  = on_now ? ((max_level > lsfc_pkg::PCT_FULL) ? lsfc_pkg::PCT_FULL
                                                            : max_level) : '0;
    elapsed     = tick_r.now_ms - last_step_time;
    elapsed_ext = {{lsfc_pkg::PCT_W{1'b0}}, elapsed};
  end

  // The step interval floor(fade / 100), at least 1, has passed exactly when
  // the elapsed time is nonzero and fade <= elapsed * 100 + 99.
  logic                       step_ok;
  logic [lsfc_pkg::PCT_W-1:0] level_next;
  logic                       written;

  always_comb begin
    step_ok = elapsed_nz && ({{lsfc_pkg::PCT_W{1'b0}}, fade_sel} <= limit);
    level_next = level;
    written    = 1'b0;
    if (!fade_enable || step_ok) begin
      if (level < target_r) begin
        level_next = fade_enable ? (level + 7'd1) : target_r;
        written    = 1'b1;
      end else if (level > target_r) begin
        level_next = fade_enable ? (level - 7'd1) : target_r;
        written    = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      lsfc_pkg::ST_IDLE: if (tick.valid) state_next = lsfc_pkg::ST_PREP;
      lsfc_pkg::ST_PREP: begin
        if (anchored_path && !forced_off) begin
          state_next = lsfc_pkg::ST_MOD;
        end else begin
          state_next = lsfc_pkg::ST_CALC;
        end
      end
      lsfc_pkg::ST_MOD:  if (cnt == lsfc_pkg::MOD_LAST) state_next = lsfc_pkg::ST_FIX;
      lsfc_pkg::ST_FIX:  state_next = lsfc_pkg::ST_DIV;
      lsfc_pkg::ST_DIV:  state_next = lsfc_pkg::ST_CALC;
      lsfc_pkg::ST_CALC: state_next = lsfc_pkg::ST_DONE;
      lsfc_pkg::ST_DONE: if (out_free) state_next = lsfc_pkg::ST_IDLE;
      default:           state_next = lsfc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: control outputs.
  always_comb begin
    out_free  = !out_valid || result.ready;
    tick_take = (state == lsfc_pkg::ST_IDLE) && tick.valid;
    out_load  = (state == lsfc_pkg::ST_DONE) && out_free;
  end

  assign tick.ready = (state == lsfc_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsfc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      lsfc_pkg::ST_IDLE: begin
        if (tick_take) begin
          tick_r        <= tick.data;
          anchored_path <= (cycle_anchor != '0) ||
                           (period_minutes != lsfc_pkg::PERIOD_DAY);
          period_sec    <= {period_minutes, 6'b0} - {4'b0, period_minutes, 2'b0};
        end
      end
      lsfc_pkg::ST_PREP: begin
        neg        <= diff[lsfc_pkg::EPOCH_W];
        dividend   <= diff[lsfc_pkg::EPOCH_W] ? diff_neg[lsfc_pkg::EPOCH_W-1:0]
                                              : diff[lsfc_pkg::EPOCH_W-1:0];
        rem        <= '0;
        cnt        <= '0;
        if (anchored_path) begin
          minute      <= '0;
          sched_valid <= !forced_off;
        end else begin
          minute      <= {{(lsfc_pkg::MINUTE_W - lsfc_pkg::MOD_W + 1){1'b0}},
                          tick_r.minute_of_day[lsfc_pkg::MOD_W-2:0]};
          sched_valid <= !tick_r.minute_of_day[lsfc_pkg::MOD_W-1];
        end
      end
      lsfc_pkg::ST_MOD: begin
        rem      <= rem_step;
        dividend <= {dividend[lsfc_pkg::EPOCH_W-2:0], fits};
        cnt      <= cnt + 6'd1;
      end
      lsfc_pkg::ST_FIX: begin
        // Remainder made non-negative before it is scaled down to minutes.
        rem <= rem_fixed;
      end
      lsfc_pkg::ST_DIV: begin
        minute <= quot_prod[lsfc_pkg::RECIP_SHIFT +: lsfc_pkg::MINUTE_W];
      end
      lsfc_pkg::ST_CALC: begin
        on_r       <= on_now;
        target_r   <= target_now;
        fade_sel   <= (level < target_now) ? fade_up_ms : fade_down_ms;
        limit      <= (elapsed_ext << 6) + (elapsed_ext << 5) + (elapsed_ext << 2) +
                      39'd99;
        elapsed_nz <= (elapsed != '0);
      end
      lsfc_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  // Level state and step timestamp.
  always_ff @(posedge clk) begin
    if (rst) begin
      level          <= '0;
      last_step_time <= '0;
    end else if (out_load) begin
      level <= level_next;
      if (fade_enable && step_ok) begin
        last_step_time <= tick_r.now_ms;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.level_pct     <= level_next;
      out_data.pwm_duty      <= lsfc_pkg::DUTY_TABLE[level_next];
      out_data.target_pct    <= target_r;
      out_data.schedule_on   <= on_r;
      out_data.level_written <= written;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

  // ---------------------------------------------------------------------------
  // Assertions.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (level <= lsfc_pkg::PCT_FULL) || (level == $past(level)))
    else $error("level left the percent range");

  a_written_matches: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_data.level_written == (level != $past(level))))
    else $error("level_written disagrees with the level change");

  a_fade_single_step: assert property (@(posedge clk) disable iff (rst)
    (out_load && fade_enable) |=>
      (level == $past(level)) || (level == $past(level) + 7'd1) ||
      (level + 7'd1 == $past(level)))
    else $error("fade moved the level by more than one");

  a_mod_count: assert property (@(posedge clk) disable iff (rst)
    (state == lsfc_pkg::ST_MOD) |-> (cnt <= lsfc_pkg::MOD_LAST))
    else $error("remainder counter ran past its last step");

  a_target_range: assert property (@(posedge clk) disable iff (rst)
    (state == lsfc_pkg::ST_DONE) |-> (target_r <= lsfc_pkg::PCT_FULL))
    else $error("target above full scale");

endmodule
